// ----- hw/rtl/hbco_pkg.sv -----
// Shared types, sizes and helper functions for the height band contour overlay.
package hbco_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int SIZE_W = 11;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int BAND_W = 7;
  localparam int RGB_W = 24;
  localparam int INDEX_W = 2;

  typedef logic [15:0] height_t;
  typedef logic [7:0] chan_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [BAND_W-1:0] band_t;
  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [INDEX_W-1:0] reg_index_t;

  localparam reg_index_t REG_IMAGE_WIDTH = 2'd0;
  localparam reg_index_t REG_IMAGE_HEIGHT = 2'd1;

  localparam rgb_t RGB_BLACK = 24'h000000;
  localparam rgb_t RGB_WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic has_above;
    logic interior;
    logic last_row;
    logic last_col;
    logic sel;
    band_t band;
    rgb_t rgb;
  } stage_t;

  function automatic size_t clamp_size(input size_t v, input size_t maxv);
    size_t r;
    if (v == '0) begin
      r = size_t'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Bands of 3.0: the integer part of the height divided by three, by reciprocal.
  function automatic band_t band_of(input height_t hs);
    logic [15:0] p;
    p = hs[15:8] * 8'd171;
    return p[15:9];
  endfunction

endpackage

// ----- hw/rtl/height_band_contour_overlay_core.sv -----
// Top level of the height band contour overlay with line stores and output pair register.
// A pixel word that completes a result word is held in s1, then moves into the output pair register.
// Throughput: one pixel word per cycle while res_stall is low; on the last row a pixel word
// below row 0 yields two result words through the single result port, so the next waits for both.
// Reset: synchronous; clears counters, bank select and pipeline, sizes return to 1024.
// Line stores are not cleared and hold undefined data until written.
module height_band_contour_overlay_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  hbco_pkg::height_t   height_sample,
  input  hbco_pkg::chan_t     red_in,
  input  hbco_pkg::chan_t     green_in,
  input  hbco_pkg::chan_t     blue_in,
  output logic                res_valid,
  input  logic                res_stall,
  output hbco_pkg::chan_t     red_out,
  output hbco_pkg::chan_t     green_out,
  output hbco_pkg::chan_t     blue_out,
  output logic                frame_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  hbco_pkg::reg_index_t cfg_index,
  input  hbco_pkg::size_t     cfg_data
);

  import hbco_pkg::*;

  size_t image_width;
  size_t image_height;
  col_t column_counter;
  row_t row_counter;
  logic bank_select;

  stage_t s1;
  logic s1_valid;
  band_t mid;
  band_t lf;
  band_t row0_band;

  logic pa;
  logic pb;
  rgb_t a_rgb;
  rgb_t b_rgb;
  logic b_last;

  size_t w_eff;
  size_t h_eff;
  logic [COL_W:0] c_inc;
  logic [ROW_W:0] r_inc;
  logic last_col;
  logic last_row;
  logic accept;
  logic out_take;
  logic pair_free;
  logic s1_move;
  band_t band;
  rgb_t rgb;
  stage_t s1_next;

  col_t rd_addr0;
  col_t rd_addr1;
  band_t rd0;
  band_t rd1;
  rgb_t col_above;
  band_t rt;
  band_t up;
  logic lower;
  logic higher;
  rgb_t res_rgb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= size_t'(MAX_WIDTH);
      image_height <= size_t'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_size(image_width, size_t'(MAX_WIDTH));
  assign h_eff = clamp_size(image_height, size_t'(MAX_HEIGHT));
  assign c_inc = {1'b0, column_counter} + 1'b1;
  assign r_inc = {1'b0, row_counter} + 1'b1;
  assign last_col = SIZE_W'(c_inc) >= w_eff;
  assign last_row = SIZE_W'(r_inc) >= h_eff;

  assign band = band_of(height_sample);
  assign rgb = {red_in, green_in, blue_in};

  assign out_take = res_valid && !res_stall;
  assign pair_free = (!pa && !pb) || (out_take && (pa ^ pb));
  assign s1_move = s1_valid && pair_free;
  assign pix_stall = s1_valid && !s1_move;
  assign accept = pix_valid && !pix_stall;

  always_comb begin
    s1_next.has_above = row_counter != '0;
    s1_next.interior = (row_counter != '0) && (row_counter != row_t'(1)) &&
                       (column_counter != '0) && !last_col;
    s1_next.last_row = last_row;
    s1_next.last_col = last_col;
    s1_next.sel = bank_select;
    s1_next.band = band;
    s1_next.rgb = rgb;
  end

  // The above row lives in the selected bank; the row two above is overwritten in place.
  assign rd_addr0 = bank_select ? column_counter : c_inc[COL_W-1:0];
  assign rd_addr1 = bank_select ? c_inc[COL_W-1:0] : column_counter;

  hbco_ram #(.WIDTH(BAND_W), .DEPTH(MAX_WIDTH)) u_band0 (
    .clk     (clk),
    .we      (accept && bank_select),
    .wr_addr (column_counter),
    .wr_data (band),
    .re      (accept),
    .rd_addr (rd_addr0),
    .rd_data (rd0)
  );

  hbco_ram #(.WIDTH(BAND_W), .DEPTH(MAX_WIDTH)) u_band1 (
    .clk     (clk),
    .we      (accept && !bank_select),
    .wr_addr (column_counter),
    .wr_data (band),
    .re      (accept),
    .rd_addr (rd_addr1),
    .rd_data (rd1)
  );

  hbco_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_colour (
    .clk     (clk),
    .we      (accept),
    .wr_addr (column_counter),
    .wr_data (rgb),
    .re      (accept),
    .rd_addr (column_counter),
    .rd_data (col_above)
  );

  assign rt = s1.sel ? rd1 : rd0;
  assign up = s1.sel ? rd0 : rd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter <= '0;
      bank_select <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (last_col) begin
          column_counter <= '0;
          bank_select <= !bank_select;
          row_counter <= last_row ? '0 : r_inc[ROW_W-1:0];
        end else begin
          column_counter <= c_inc[COL_W-1:0];
        end
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // The left, centre and right bands of the above row slide along with each pixel word.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
      lf <= mid;
      if (column_counter == '0) begin
        mid <= row0_band;
        row0_band <= band;
      end else begin
        mid <= rt;
      end
    end
  end

  assign lower = (mid < up) || (mid < lf) || (mid < rt) || (mid < s1.band);
  assign higher = (mid > up) || (mid > lf) || (mid > rt) || (mid > s1.band);

  always_comb begin
    priority if (!s1.interior) begin
      res_rgb = col_above;
    end else if (lower) begin
      res_rgb = RGB_BLACK;
    end else if (higher) begin
      res_rgb = RGB_WHITE;
    end else begin
      res_rgb = col_above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa <= 1'b0;
      pb <= 1'b0;
    end else if (s1_move) begin
      pa <= s1.has_above;
      pb <= s1.last_row;
    end else if (out_take) begin
      if (pa) begin
        pa <= 1'b0;
      end else begin
        pb <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      a_rgb <= res_rgb;
      b_rgb <= s1.rgb;
      b_last <= s1.last_col;
    end
  end

  assign res_valid = pa || pb;
  assign red_out = pa ? a_rgb[23:16] : b_rgb[23:16];
  assign green_out = pa ? a_rgb[15:8] : b_rgb[15:8];
  assign blue_out = pa ? a_rgb[7:0] : b_rgb[7:0];
  assign frame_last = pa ? 1'b0 : b_last;

endmodule

// ----- hw/rtl/hbco_ram.sv -----
// Generic simple dual-port RAM with a registered, enabled read port.
module hbco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the contour overlay core: directed frames, then random frames.
module testbench;
  import hbco_pkg::*;

  localparam reg_index_t REG_SPARE_LO = 2'd2;
  localparam reg_index_t REG_SPARE_HI = 2'd3;
  localparam int BAND_STEP = 768;
  localparam int TOP_BAND = 85;
  localparam int HOLD_CYCLES = 240;
  localparam int DRAIN_CYCLES = 8;
  localparam int SMALL_FRAME_ITEMS = 860;
  localparam int TALL_ROWS = 1024;
  localparam int TAIL_ITEMS = 64;
  localparam int END_WAIT_CYCLES = 20000;

  typedef struct packed {
    rgb_t rgb;
    logic last;
  } overlay_word_t;

  typedef struct packed {
    bit         is_cfg;
    reg_index_t idx;
    size_t      data;
    height_t    hs;
    rgb_t       rgb;
    bit         typed;
    rgb_t       exp_rgb;
    logic       exp_last;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       pix_valid;
  logic       pix_stall;
  height_t    height_sample;
  chan_t      red_in;
  chan_t      green_in;
  chan_t      blue_in;
  logic       res_valid;
  logic       res_stall;
  chan_t      red_out;
  chan_t      green_out;
  chan_t      blue_out;
  logic       frame_last;
  logic       cfg_valid;
  logic       cfg_ready;
  reg_index_t cfg_index;
  size_t      cfg_data;

  size_t         width_reg;
  size_t         height_reg;
  int unsigned   col_pos;
  int unsigned   row_pos;
  bit            bank_sel;
  band_t         band_line [2][MAX_WIDTH];
  rgb_t          colour_line [MAX_WIDTH];
  overlay_word_t pending_pixels [$];
  stim_row_t     directed_tab [$];
  int            mismatch_count;
  bit            send_gaps;
  bit            recv_gaps;
  bit            hold_req;

  height_band_contour_overlay_core dut (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .height_sample (height_sample),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .frame_last    (frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAIL height_band_contour_overlay_core");
    $finish;
  end

  function automatic int unsigned eff_size(input size_t v, input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic stim_row_t cfg_row(input reg_index_t idx, input size_t data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t pix_row(input height_t hs, input rgb_t rgb, input bit typed,
                                        input rgb_t exp_rgb, input logic exp_last);
    stim_row_t row;
    row = '0;
    row.hs = hs;
    row.rgb = rgb;
    row.typed = typed;
    row.exp_rgb = exp_rgb;
    row.exp_last = exp_last;
    return row;
  endfunction

  // Works out the result words caused by one pixel word and advances the line model.
  task automatic predict_overlay(input height_t hs, input rgb_t rgb, output int n);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int unsigned   r;
    band_t         band;
    band_t         mid;
    band_t         up;
    band_t         lf;
    band_t         rt;
    bit            last_row;
    bit            last_col;
    overlay_word_t word;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    band = band_t'(hs / BAND_STEP);
    last_row = (r + 1 >= h);
    last_col = (c + 1 >= w);
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    n = 0;
    if (r > 0) begin
      word.rgb = colour_line[c];
      word.last = 1'b0;
      if (r != 1 && c != 0 && c + 1 < w) begin
        mid = band_line[bank_sel][c];
        up = band_line[!bank_sel][c];
        lf = band_line[bank_sel][c - 1];
        rt = band_line[bank_sel][c + 1];
        if (mid < up || mid < lf || mid < rt || mid < band) begin
          word.rgb = RGB_BLACK;
        end else if (mid > up || mid > lf || mid > rt || mid > band) begin
          word.rgb = RGB_WHITE;
        end
      end
      pending_pixels.push_back(word);
      n++;
    end
    if (last_row) begin
      word.rgb = rgb;
      word.last = last_col;
      pending_pixels.push_back(word);
      n++;
    end
    colour_line[c] = rgb;
    band_line[!bank_sel][c] = band;
    if (last_col) begin
      col_pos = 0;
      bank_sel = !bank_sel;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic send_pixel(input height_t hs, input rgb_t rgb, output int n);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      pix_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pix_valid = 1'b1;
    height_sample = hs;
    {red_in, green_in, blue_in} = rgb;
    do @(posedge clk); while (pix_stall);
    predict_overlay(hs, rgb, n);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input size_t data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = data;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = data;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    pix_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Most words sit within one band of a per-frame base, so contours are frequent.
  task automatic send_frame(input int unsigned w, input int unsigned h);
    int unsigned base;
    int unsigned b;
    int unsigned v;
    int          n;
    base = $urandom_range(0, TOP_BAND);
    repeat (w * h) begin
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom_range(0, 65535);
      end else begin
        b = base + $urandom_range(0, 2);
        b = (b > 0) ? b - 1 : 0;
        if (b > TOP_BAND) b = TOP_BAND;
        v = b * BAND_STEP + $urandom_range(0, BAND_STEP - 1);
        if (v > 65535) v = 65535;
      end
      send_pixel(height_t'(v), rgb_t'($urandom), n);
    end
  endtask

  task automatic compare_channel(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    overlay_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("result word with none expected: rgb %06h, frame_last %0d",
               {red_out, green_out, blue_out}, frame_last);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        compare_channel("red_out", want.rgb[23:16], red_out);
        compare_channel("green_out", want.rgb[15:8], green_out);
        compare_channel("blue_out", want.rgb[7:0], blue_out);
        compare_channel("frame_last", want.last, frame_last);
      end
    end
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        res_stall = 1'b0;
        hold_req = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        res_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        res_stall = 1'b0;
      end
    end
  end

  initial begin
    stim_row_t   row;
    int          n;
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned waited;
    size_t       wsel;
    size_t       hsel;
    rst = 1'b1;
    pix_valid = 1'b0;
    height_sample = '0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    mismatch_count = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_req = 1'b0;
    width_reg = size_t'(MAX_WIDTH);
    height_reg = size_t'(MAX_HEIGHT);
    col_pos = 0;
    row_pos = 0;
    bank_sel = 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      band_line[0][i] = '0;
      band_line[1][i] = '0;
      colour_line[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // A 3x3 frame whose centre lies below the band above it, so it turns black.
    directed_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 11'd3));
    directed_tab.push_back(cfg_row(REG_IMAGE_HEIGHT, 11'd3));
    directed_tab.push_back(pix_row(16'd0, 24'hFF0000, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd65535, 24'h00FF00, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd767, 24'h0000FF, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd768, 24'hFFFFFF, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd1535, 24'h808080, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd2304, 24'h000000, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd100, 24'h00FFFF, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd1536, 24'hFF00FF, 1'b1, RGB_BLACK, 1'b0));
    directed_tab.push_back(pix_row(16'd200, 24'hFFFF00, 1'b0, '0, 1'b0));
    // A 3x3 frame whose centre lies above its left neighbour only, so it turns white.
    directed_tab.push_back(pix_row(16'd3000, 24'h0A0B0C, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd3000, 24'h102030, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd3000, 24'h405060, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd2303, 24'h708090, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd3071, 24'h7F7F7F, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd2500, 24'hA0B0C0, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd2400, 24'hD0E0F0, 1'b0, '0, 1'b0));
    directed_tab.push_back(pix_row(16'd3071, 24'h123456, 1'b1, RGB_WHITE, 1'b0));
    directed_tab.push_back(pix_row(16'd0, 24'h654321, 1'b0, '0, 1'b0));
    // Zero sizes act as one: every word is a whole frame and passes unchanged.
    directed_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 11'd0));
    directed_tab.push_back(cfg_row(REG_IMAGE_HEIGHT, 11'd0));
    directed_tab.push_back(pix_row(16'd65535, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1));
    directed_tab.push_back(pix_row(16'd0, 24'h000000, 1'b1, 24'h000000, 1'b1));
    // Writes to the unused indexes must leave both sizes alone.
    directed_tab.push_back(cfg_row(REG_SPARE_LO, 11'd2047));
    directed_tab.push_back(cfg_row(REG_SPARE_HI, 11'h555));
    directed_tab.push_back(pix_row(16'h5A5A, 24'h5AA5C3, 1'b1, 24'h5AA5C3, 1'b1));

    foreach (directed_tab[i]) begin
      row = directed_tab[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_pixel(row.hs, row.rgb, n);
        if (row.typed && n > 0) begin
          pending_pixels[pending_pixels.size() - n] = {row.exp_rgb, row.exp_last};
        end
      end
    end

    // Tallest frame, one column wide, with a long receiver hold at its start.
    settle();
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, 11'd2047);
    hold_req = 1'b1;
    send_frame(1, TALL_ROWS);

    sent = 0;
    while (sent < SMALL_FRAME_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: wsel = 11'd0;
        1: wsel = 11'd1;
        2: wsel = 11'd2;
        3, 4, 5, 6: wsel = size_t'($urandom_range(3, 8));
        7, 8: wsel = size_t'($urandom_range(9, 24));
        default: wsel = size_t'($urandom_range(25, 64));
      endcase
      case ($urandom_range(0, 7))
        0: hsel = 11'd0;
        1: hsel = 11'd1;
        2: hsel = 11'd2;
        default: hsel = size_t'($urandom_range(3, 6));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_IMAGE_WIDTH, wsel);
        write_reg(REG_IMAGE_HEIGHT, hsel);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, hsel);
        write_reg(REG_IMAGE_WIDTH, wsel);
      end
      w = eff_size(wsel, MAX_WIDTH);
      h = eff_size(hsel, MAX_HEIGHT);
      repeat ($urandom_range(1, 3)) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps = ($urandom_range(0, 3) != 0);
        send_frame(w, h);
        sent += w * h;
      end
    end

    // Oversized width acts as the widest row; the frame is one row high and left open.
    settle();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 11'd2047);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    repeat (TAIL_ITEMS) send_pixel(height_t'($urandom), rgb_t'($urandom), n);
    pix_valid = 1'b0;

    waited = 0;
    while (pending_pixels.size() != 0 && waited < END_WAIT_CYCLES) begin
      @(negedge clk);
      waited++;
    end
    repeat (4 * DRAIN_CYCLES) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d expected result words never arrived", pending_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS height_band_contour_overlay_core");
    end else begin
      $display("FAIL height_band_contour_overlay_core");
    end
    $finish;
  end

endmodule
